[rtl/spec_pkg.sv]
package spec_pkg;

  // Default sizes of the stores and of the cell row.
  localparam int MAX_POINTS_DEF    = 256;
  localparam int BASE_TYPES_DEF    = 4;
  localparam int MAX_NEIGHBORS_DEF = 512;
  localparam int NUM_CELLS_DEF     = 8;

  localparam int COORD_W = 20;
  localparam int RADIUS_W = 24;
  localparam int POINTS_W = 9;
  localparam int COUNT_W = 9;
  localparam int CFG_DATA_W = 24;

  // Register reset values: 3.2 squared in 1/65536 units, and 200 points.
  localparam logic [RADIUS_W-1:0] RADIUS_SQ_RESET = 24'd671089;
  localparam logic [POINTS_W-1:0] POINTS_RESET    = 9'd200;

  // Configuration register indexes.
  localparam logic CFG_RADIUS_SQ = 1'b0;
  localparam logic CFG_POINTS    = 1'b1;

  // Command codes.
  localparam logic [1:0] CMD_WRITE_POINT = 2'd0;
  localparam logic [1:0] CMD_APPEND      = 2'd1;
  localparam logic [1:0] CMD_EVALUATE    = 2'd2;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
  } pos_t;

  // A neighbor travelling along the cell row.
  typedef struct packed {
    logic valid;
    pos_t pos;
  } nb_tok_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_STREAM,
    ST_DRAIN,
    ST_COUNT,
    ST_FINISH
  } state_t;

endpackage

[rtl/spec_ram.sv]
module spec_ram #(
  parameter int WIDTH = 60,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

[rtl/spec_cell.sv]
module spec_cell (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             load_en,
  input  spec_pkg::pos_t                   samp_in,
  input  logic                             ok_in,
  input  spec_pkg::nb_tok_t                nb_in,
  input  logic [spec_pkg::RADIUS_W-1:0]    radius_sq,
  output spec_pkg::pos_t                   samp_out,
  output logic                             ok_out,
  output spec_pkg::nb_tok_t                nb_out,
  output logic                             exposed
);

  localparam int DW = spec_pkg::COORD_W + 1;
  localparam int SW = 2 * DW;

  spec_pkg::pos_t    samp_r;
  logic              ok_r;
  logic              buried_r;
  logic              nb_v_r;
  spec_pkg::pos_t    nb_pos_r;

  logic                 a_v_r;
  logic signed [DW-1:0] dx_r, dy_r, dz_r;
  logic                 b_v_r;
  logic [SW-1:0]        sqx_r, sqy_r, sqz_r;

  logic [DW-1:0] mx, my, mz;
  logic [SW-1:0] sqx, sqy, sqz;
  logic [SW:0]   dist_sq;

  // Magnitudes of the differences fit in DW unsigned bits.
  assign mx = dx_r[DW-1] ? (~dx_r + DW'(1)) : dx_r;
  assign my = dy_r[DW-1] ? (~dy_r + DW'(1)) : dy_r;
  assign mz = dz_r[DW-1] ? (~dz_r + DW'(1)) : dz_r;
  assign sqx = mx * mx;
  assign sqy = my * my;
  assign sqz = mz * mz;
  assign dist_sq = (SW+1)'(sqx_r) + (SW+1)'(sqy_r) + (SW+1)'(sqz_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ok_r     <= 1'b0;
      buried_r <= 1'b0;
      nb_v_r   <= 1'b0;
      a_v_r    <= 1'b0;
      b_v_r    <= 1'b0;
    end else begin
      nb_v_r     <= nb_in.valid;
      a_v_r      <= nb_in.valid;
      b_v_r      <= a_v_r;
      if (load_en) begin
        ok_r     <= ok_in;
        buried_r <= 1'b0;
      end else if (b_v_r && (dist_sq < (SW+1)'(radius_sq))) begin
        buried_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_en) begin
      samp_r <= samp_in;
    end
    nb_pos_r <= nb_in.pos;
    dx_r  <= DW'(samp_r.x) - DW'(nb_in.pos.x);
    dy_r  <= DW'(samp_r.y) - DW'(nb_in.pos.y);
    dz_r  <= DW'(samp_r.z) - DW'(nb_in.pos.z);
    sqx_r <= sqx;
    sqy_r <= sqy;
    sqz_r <= sqz;
  end

  assign samp_out     = samp_r;
  assign ok_out       = ok_r;
  assign nb_out.valid = nb_v_r;
  assign nb_out.pos   = nb_pos_r;
  assign exposed      = ok_r & ~buried_r;

endmodule

[rtl/surface_point_exposure_count.sv]
// Write-point and append items leave the block idle; busy stays low for them, so the next item can follow at once.
// Evaluate keeps busy high until the result strobe, which comes in the last busy cycle;
// the receiver cannot hold it off, so the next item is taken in the cycle after the strobe.
// Synchronous active-low reset empties the neighbor list, clears the overflow flag and
// restores the configuration registers; the sample table is undefined until written.
module surface_point_exposure_count #(
  parameter int MAX_POINTS    = spec_pkg::MAX_POINTS_DEF,
  parameter int BASE_TYPES    = spec_pkg::BASE_TYPES_DEF,
  parameter int MAX_NEIGHBORS = spec_pkg::MAX_NEIGHBORS_DEF,
  parameter int NUM_CELLS     = spec_pkg::NUM_CELLS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic [1:0]                        in_command,
  input  logic [1:0]                        in_base_type,
  input  logic [7:0]                        in_point_index,
  input  logic signed [spec_pkg::COORD_W-1:0] in_coord_x,
  input  logic signed [spec_pkg::COORD_W-1:0] in_coord_y,
  input  logic signed [spec_pkg::COORD_W-1:0] in_coord_z,
  output logic                              out_valid,
  output logic [spec_pkg::COUNT_W-1:0]      out_exposed_count,
  output logic                              out_list_overflowed,
  input  logic                              cfg_we,
  input  logic                              cfg_index,
  input  logic [spec_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int AW        = $clog2(BASE_TYPES * MAX_POINTS);
  localparam int NAW       = $clog2(MAX_NEIGHBORS);
  localparam int NCW       = $clog2(MAX_NEIGHBORS + 1);
  localparam int PCW       = $clog2(MAX_POINTS + 1);
  localparam int BW        = $clog2(MAX_POINTS + NUM_CELLS + 1);
  localparam int KW        = $clog2(NUM_CELLS + 1);
  localparam int DRAIN_LEN = NUM_CELLS + 4;
  localparam int DW        = $clog2(DRAIN_LEN + 1);
  localparam int POPW      = $clog2(NUM_CELLS + 1);
  localparam int PW        = $bits(spec_pkg::pos_t);

  spec_pkg::state_t state_r, state_nxt;

  logic [spec_pkg::RADIUS_W-1:0] radius_sq_r;
  logic [spec_pkg::POINTS_W-1:0] points_r;
  logic [NCW-1:0]                nb_cnt_r;
  logic                          ovf_r;
  logic [KW-1:0]                 k_r;
  logic [NCW-1:0]                j_r;
  logic [DW-1:0]                 dr_r;
  logic                          ld_v_r;
  logic                          ld_ok_r;
  logic                          nbv_r;
  logic [PCW-1:0]                n_r;
  logic [1:0]                    type_r;
  logic [BW-1:0]                 base_r;
  logic [PCW-1:0]                exposed_r;

  logic           accept;
  logic           wr_samp, wr_nb, set_ovf, eval_go, eval_empty;
  logic           type_ok;
  logic [PCW-1:0] n_eff;
  logic           load_issue, nb_issue, count_en, finish;
  logic [BW-1:0]  pidx;
  logic           pidx_ok;
  logic [AW-1:0]  samp_waddr, samp_raddr;
  logic [PW-1:0]  samp_rdata, nb_rdata;
  spec_pkg::pos_t in_pos;
  logic [POPW-1:0] pop;

  spec_pkg::pos_t    samp_link [NUM_CELLS+1];
  logic              ok_link   [NUM_CELLS+1];
  spec_pkg::nb_tok_t nb_link   [NUM_CELLS+1];
  logic [NUM_CELLS-1:0] exp_vec;

  assign accept   = start & ~busy;
  assign in_pos.x = in_coord_x;
  assign in_pos.y = in_coord_y;
  assign in_pos.z = in_coord_z;

  assign type_ok = 32'(in_base_type) < BASE_TYPES;
  assign n_eff   = (32'(points_r) > MAX_POINTS) ? PCW'(MAX_POINTS) : PCW'(points_r);

  // Item decode; only taken while idle.
  always_comb begin
    wr_samp    = 1'b0;
    wr_nb      = 1'b0;
    set_ovf    = 1'b0;
    eval_go    = 1'b0;
    eval_empty = 1'b0;
    if (accept) begin
      unique case (in_command)
        spec_pkg::CMD_WRITE_POINT: begin
          wr_samp = type_ok && (32'(in_point_index) < MAX_POINTS);
        end
        spec_pkg::CMD_APPEND: begin
          wr_nb   = nb_cnt_r < NCW'(MAX_NEIGHBORS);
          set_ovf = nb_cnt_r >= NCW'(MAX_NEIGHBORS);
        end
        spec_pkg::CMD_EVALUATE: begin
          eval_go    = 1'b1;
          eval_empty = !type_ok || (n_eff == '0);
        end
        default: begin
        end
      endcase
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      spec_pkg::ST_IDLE: begin
        if (eval_go) begin
          state_nxt = eval_empty ? spec_pkg::ST_FINISH : spec_pkg::ST_LOAD;
        end
      end
      spec_pkg::ST_LOAD: begin
        if (k_r == KW'(NUM_CELLS - 1)) begin
          state_nxt = (nb_cnt_r == '0) ? spec_pkg::ST_DRAIN : spec_pkg::ST_STREAM;
        end
      end
      spec_pkg::ST_STREAM: begin
        if (j_r == nb_cnt_r - NCW'(1)) begin
          state_nxt = spec_pkg::ST_DRAIN;
        end
      end
      spec_pkg::ST_DRAIN: begin
        if (dr_r == DW'(DRAIN_LEN - 1)) begin
          state_nxt = spec_pkg::ST_COUNT;
        end
      end
      spec_pkg::ST_COUNT: begin
        if ((base_r + BW'(NUM_CELLS)) >= BW'(n_r)) begin
          state_nxt = spec_pkg::ST_FINISH;
        end else begin
          state_nxt = spec_pkg::ST_LOAD;
        end
      end
      spec_pkg::ST_FINISH: begin
        state_nxt = spec_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = spec_pkg::ST_IDLE;
      end
    endcase
  end

  // State outputs.
  always_comb begin
    busy       = 1'b1;
    load_issue = 1'b0;
    nb_issue   = 1'b0;
    count_en   = 1'b0;
    finish     = 1'b0;
    unique case (state_r)
      spec_pkg::ST_IDLE:   busy       = 1'b0;
      spec_pkg::ST_LOAD:   load_issue = 1'b1;
      spec_pkg::ST_STREAM: nb_issue   = 1'b1;
      spec_pkg::ST_DRAIN:  busy       = 1'b1;
      spec_pkg::ST_COUNT:  count_en   = 1'b1;
      spec_pkg::ST_FINISH: finish     = 1'b1;
      default:             busy       = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= spec_pkg::ST_IDLE;
      radius_sq_r <= spec_pkg::RADIUS_SQ_RESET;
      points_r    <= spec_pkg::POINTS_RESET;
      nb_cnt_r    <= '0;
      ovf_r       <= 1'b0;
      k_r         <= '0;
      j_r         <= '0;
      dr_r        <= '0;
      ld_v_r      <= 1'b0;
      nbv_r       <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          spec_pkg::CFG_RADIUS_SQ: radius_sq_r <= cfg_data[spec_pkg::RADIUS_W-1:0];
          spec_pkg::CFG_POINTS:    points_r    <= cfg_data[spec_pkg::POINTS_W-1:0];
          default: begin
          end
        endcase
      end
      if (finish) begin
        nb_cnt_r <= '0;
        ovf_r    <= 1'b0;
      end else begin
        if (wr_nb) begin
          nb_cnt_r <= nb_cnt_r + NCW'(1);
        end
        if (set_ovf) begin
          ovf_r <= 1'b1;
        end
      end
      k_r    <= load_issue ? k_r + KW'(1) : '0;
      j_r    <= nb_issue ? j_r + NCW'(1) : '0;
      dr_r   <= (state_r == spec_pkg::ST_DRAIN) ? dr_r + DW'(1) : '0;
      ld_v_r <= load_issue;
      nbv_r  <= nb_issue;
    end
  end

  always_ff @(posedge clk) begin
    ld_ok_r <= pidx_ok;
    if (eval_go) begin
      n_r       <= n_eff;
      type_r    <= in_base_type;
      base_r    <= '0;
      exposed_r <= '0;
    end else if (count_en) begin
      base_r    <= base_r + BW'(NUM_CELLS);
      exposed_r <= exposed_r + PCW'(pop);
    end
  end

  // Sample point read for the batch being loaded.
  assign pidx    = base_r + BW'(k_r);
  assign pidx_ok = load_issue && (pidx < BW'(n_r));
  assign samp_raddr = pidx_ok ? (AW'(type_r) * AW'(MAX_POINTS) + AW'(pidx)) : '0;
  assign samp_waddr = AW'(in_base_type) * AW'(MAX_POINTS) + AW'(in_point_index);

  spec_ram #(
    .WIDTH (PW),
    .DEPTH (BASE_TYPES * MAX_POINTS)
  ) u_samp_ram (
    .clk   (clk),
    .we    (wr_samp),
    .waddr (samp_waddr),
    .wdata (in_pos),
    .raddr (samp_raddr),
    .rdata (samp_rdata)
  );

  spec_ram #(
    .WIDTH (PW),
    .DEPTH (MAX_NEIGHBORS)
  ) u_nb_ram (
    .clk   (clk),
    .we    (wr_nb),
    .waddr (nb_cnt_r[NAW-1:0]),
    .wdata (in_pos),
    .raddr (j_r[NAW-1:0]),
    .rdata (nb_rdata)
  );

  // A batch of NUM_CELLS sample points shifts in from the head of the row and then
  // holds still while every stored neighbor follows the same path, one per cycle.
  assign samp_link[0]     = samp_rdata;
  assign ok_link[0]       = ld_ok_r;
  assign nb_link[0].valid = nbv_r;
  assign nb_link[0].pos   = nb_rdata;

  for (genvar c = 0; c < NUM_CELLS; c++) begin : g_cell
    spec_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .load_en   (ld_v_r),
      .samp_in   (samp_link[c]),
      .ok_in     (ok_link[c]),
      .nb_in     (nb_link[c]),
      .radius_sq (radius_sq_r),
      .samp_out  (samp_link[c+1]),
      .ok_out    (ok_link[c+1]),
      .nb_out    (nb_link[c+1]),
      .exposed   (exp_vec[c])
    );
  end

  always_comb begin
    pop = '0;
    for (int c = 0; c < NUM_CELLS; c++) begin
      pop = pop + POPW'(exp_vec[c]);
    end
  end

  assign out_valid           = finish;
  assign out_exposed_count   = (32'(exposed_r) > 511) ? spec_pkg::COUNT_W'(511)
                                                       : spec_pkg::COUNT_W'(exposed_r);
  assign out_list_overflowed = ovf_r;

endmodule
